// ----- hw/rtl/fpsrs_pkg.sv -----
// ----------------------------------------------------------------------------
// fpsrs_pkg
// Shared types and constants of the point-assign / range-sum core.
// ----------------------------------------------------------------------------
package fpsrs_pkg;

  localparam int IDX_W   = 11;
  localparam int VAL_W   = 32;
  localparam int NODE_W  = 42;
  localparam int S_DATA_W = 56;   // first_index, last_index, new_value, pad
  localparam int M_DATA_W = 48;   // range_total, pad

  localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic ACT_ASSIGN = 1'b0;
  localparam logic ACT_SUM    = 1'b1;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_LOAD  = 8'b0000_0100,
    ST_A_DLT = 8'b0000_1000,
    ST_A_ADD = 8'b0001_0000,
    ST_S_UP  = 8'b0010_0000,
    ST_S_DN  = 8'b0100_0000,
    ST_POST  = 8'b1000_0000
  } state_t;

  function automatic logic [NODE_W-1:0] sext_node(input logic [VAL_W-1:0] v);
    return {{(NODE_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

// ----- hw/rtl/fpsrs_addsub.sv -----
// ----------------------------------------------------------------------------
// fpsrs_addsub
// Shared 42-bit add/subtract unit, used for deltas, node updates and sums.
// ----------------------------------------------------------------------------
module fpsrs_addsub
  import fpsrs_pkg::*;
(
  input  logic [NODE_W-1:0] a,
  input  logic [NODE_W-1:0] b,
  input  logic              sub,
  output logic [NODE_W-1:0] y
);

  assign y = sub ? (a - b) : (a + b);

endmodule

// ----- hw/rtl/fpsrs_store.sv -----
// ----------------------------------------------------------------------------
// fpsrs_store
// Tree node memory and entry value memory, one write and one registered
// read port each.
// ----------------------------------------------------------------------------
module fpsrs_store
  import fpsrs_pkg::*;
#(
  parameter int DEPTH = 1025,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              tree_we,
  input  logic [AW-1:0]     tree_waddr,
  input  logic [NODE_W-1:0] tree_wdata,
  input  logic [AW-1:0]     tree_raddr,
  output logic [NODE_W-1:0] tree_rdata,
  input  logic              entry_we,
  input  logic [AW-1:0]     entry_waddr,
  input  logic [VAL_W-1:0]  entry_wdata,
  input  logic [AW-1:0]     entry_raddr,
  output logic [VAL_W-1:0]  entry_rdata
);

  logic [NODE_W-1:0] tree_mem  [0:DEPTH-1];
  logic [VAL_W-1:0]  entry_mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    tree_rdata <= tree_mem[tree_raddr];
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= entry_wdata;
    end
    entry_rdata <= entry_mem[entry_raddr];
  end

endmodule

// ----- hw/rtl/fenwick_point_set_range_sum_core.sv -----
// ----------------------------------------------------------------------------
// fenwick_point_set_range_sum_core
// Binary indexed tree over a table of signed entries: point assign and
// range sum, one item at a time through a shared adder and two memories.
// ----------------------------------------------------------------------------
// results: a sum shows its result after its walk up prefix(last) and down prefix(first-1);
// a rejected item goes straight to the result state; an assign gives none
// throughput: one item at a time, one tree node per cycle through the single adder;
// an assign frees the input once its upward path leaves the table, a sum or a rejected
// item as its result loads into the output register, later on a stall
// reset: synchronous, then a clearing pass over all TABLE_SIZE+1 entries with s_tready low
module fenwick_point_set_range_sum_core
  import fpsrs_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_wdata,   // size_in_use
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,     // first_index, last_index, new_value, zero pad
  input  logic                s_tuser,     // action
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,     // range_total, zero pad
  output logic                m_tuser      // index_error
);

  localparam int AW    = $clog2(TABLE_SIZE + 1);
  localparam int KW    = AW + 1;
  localparam int DEPTH = TABLE_SIZE + 1;

  state_t            state;
  logic [AW-1:0]     clr_cnt;
  logic [IDX_W-1:0]  size_in_use;
  logic              act;
  logic [IDX_W-1:0]  fi;
  logic [IDX_W-1:0]  li;
  logic [VAL_W-1:0]  nv;
  logic [KW-1:0]     p;
  logic [NODE_W-1:0] delta;
  logic [NODE_W-1:0] acc;
  logic              err;
  logic [NODE_W-1:0] out_total;
  logic              out_err;

  logic              tree_we;
  logic [AW-1:0]     tree_waddr;
  logic [NODE_W-1:0] tree_wdata;
  logic [AW-1:0]     tree_raddr;
  logic [NODE_W-1:0] tree_rdata;
  logic              entry_we;
  logic [AW-1:0]     entry_waddr;
  logic [VAL_W-1:0]  entry_rdata;
  logic [AW-1:0]     entry_raddr;

  logic [NODE_W-1:0] alu_a;
  logic [NODE_W-1:0] alu_b;
  logic              alu_sub;
  logic [NODE_W-1:0] alu_y;

  logic [KW-1:0]     p_up;
  logic [KW-1:0]     p_dn;
  logic [KW-1:0]     q;
  logic              p_up_in;
  logic              fi_ok;
  logic              li_ok;
  logic              req_ok;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{(M_DATA_W-NODE_W){1'b0}}, out_total};
  assign m_tuser  = out_err;

  // index arithmetic of the tree walk
  assign p_up    = p + (p & (~p + KW'(1)));
  assign p_dn    = p & (p - KW'(1));
  assign q       = KW'(fi) - KW'(1);
  assign p_up_in = (32'(p_up) <= TABLE_SIZE);

  assign fi_ok  = (fi != '0) && (fi <= size_in_use) && (32'(fi) <= TABLE_SIZE);
  assign li_ok  = (li != '0) && (li <= size_in_use) && (32'(li) <= TABLE_SIZE);
  assign req_ok = (act == ACT_SUM) ? (fi_ok && li_ok) : fi_ok;

  fpsrs_addsub u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  fpsrs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk         (clk),
    .tree_we     (tree_we),
    .tree_waddr  (tree_waddr),
    .tree_wdata  (tree_wdata),
    .tree_raddr  (tree_raddr),
    .tree_rdata  (tree_rdata),
    .entry_we    (entry_we),
    .entry_waddr (entry_waddr),
    .entry_wdata ((state == ST_CLEAR) ? '0 : nv),
    .entry_raddr (entry_raddr),
    .entry_rdata (entry_rdata)
  );

  // memory ports and adder operands
  always_comb begin
    tree_we     = 1'b0;
    tree_waddr  = p[AW-1:0];
    tree_wdata  = alu_y;
    tree_raddr  = p[AW-1:0];
    entry_we    = 1'b0;
    entry_waddr = p[AW-1:0];
    entry_raddr = p[AW-1:0];
    alu_a       = acc;
    alu_b       = tree_rdata;
    alu_sub     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        tree_we     = 1'b1;
        entry_we    = 1'b1;
        tree_waddr  = clr_cnt;
        entry_waddr = clr_cnt;
        tree_wdata  = '0;
      end
      ST_IDLE: begin
      end
      ST_LOAD: begin
        entry_raddr = AW'(fi);
        tree_raddr  = (act == ACT_SUM) ? AW'(li) : AW'(fi);
      end
      ST_A_DLT: begin
        alu_a    = sext_node(nv);
        alu_b    = sext_node(entry_rdata);
        alu_sub  = 1'b1;
        entry_we = 1'b1;
      end
      ST_A_ADD: begin
        alu_a      = tree_rdata;
        alu_b      = delta;
        tree_we    = 1'b1;
        tree_raddr = p_up[AW-1:0];
      end
      ST_S_UP: begin
        tree_raddr = (p_dn != '0) ? p_dn[AW-1:0] : q[AW-1:0];
      end
      ST_S_DN: begin
        alu_sub    = 1'b1;
        tree_raddr = p_dn[AW-1:0];
      end
      ST_POST: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      size_in_use <= SIZE_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_in_use <= cfg_wdata;
      end
      // the result state reloads the output register on its own
      if (m_tvalid && m_tready && (state != ST_POST)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(TABLE_SIZE)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            act   <= s_tuser;
            fi    <= s_tdata[IDX_W-1:0];
            li    <= s_tdata[2*IDX_W-1:IDX_W];
            nv    <= s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          p   <= (act == ACT_SUM) ? KW'(li) : KW'(fi);
          acc <= '0;
          err <= !req_ok;
          if (!req_ok) begin
            state <= ST_POST;
          end else if (act == ACT_SUM) begin
            state <= ST_S_UP;
          end else begin
            state <= ST_A_DLT;
          end
        end
        ST_A_DLT: begin
          delta <= alu_y;
          state <= ST_A_ADD;
        end
        ST_A_ADD: begin
          if (p_up_in) begin
            p <= p_up;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_S_UP: begin
          acc <= alu_y;
          if (p_dn != '0) begin
            p <= p_dn;
          end else if (q != '0) begin
            p     <= q;
            state <= ST_S_DN;
          end else begin
            state <= ST_POST;
          end
        end
        ST_S_DN: begin
          acc <= alu_y;
          if (p_dn != '0) begin
            p <= p_dn;
          end else begin
            state <= ST_POST;
          end
        end
        ST_POST: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            out_total <= acc;
            out_err   <= err;
            m_tvalid  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/fpsrs_chk.sv -----
// ----------------------------------------------------------------------------
// fpsrs_chk
// Port-level checks of the point-assign / range-sum core, bound to the top.
// ----------------------------------------------------------------------------
module fpsrs_chk
  import fpsrs_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser
);

  // clearing pass keeps the input closed right after reset
  a_clear_after_rst: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready in the cycle after a transfer");

  // a rejected request carries a zero total
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("error result with nonzero total");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind fenwick_point_set_range_sum_core fpsrs_chk u_fpsrs_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
